>>> design/kwsc_pkg.sv
// ----------------------------------------------------------------------------
// kwsc_pkg
// Shared types, constants and helpers for the keyword substitution cipher.
// ----------------------------------------------------------------------------
package kwsc_pkg;

  // alphabet size and table address width
  localparam int ALPHA_SIZE = 26;
  localparam int ALPHA_AW   = 5;

  // default keyword length bound
  localparam int MAX_KEY_LETTERS_DEF = 8;

  // configuration port geometry
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  // register indexes (paddr[4:3])
  typedef enum logic [1:0] {
    REG_KEY_LETTERS = 2'd0,
    REG_KEY_LENGTH  = 2'd1,
    REG_DIRECTION   = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  // register file contents
  typedef struct packed {
    logic [63:0] key_letters;
    logic [3:0]  key_length;
    logic        direction;
  } cfg_t;

  // table write port
  typedef struct packed {
    logic                en;
    logic [ALPHA_AW-1:0] addr;
    logic [ALPHA_AW-1:0] data;
  } ram_wr_t;

  // builder sequencer states
  typedef enum logic [1:0] {
    BLD_IDLE,
    BLD_KEY,
    BLD_FILL
  } bld_state_t;

  // letter classification
  typedef struct packed {
    logic                hit;
    logic [ALPHA_AW-1:0] idx;
  } letter_t;

  localparam logic [7:0] ASCII_LC_A = 8'h61;
  localparam logic [7:0] ASCII_LC_Z = 8'h7a;
  localparam logic [7:0] ASCII_UC_A = 8'h41;
  localparam logic [7:0] ASCII_UC_Z = 8'h5a;

  // case-folded alphabet position of a byte, hit low for non-letters
  function automatic letter_t letter_index(logic [7:0] b);
    letter_t     r;
    logic [7:0]  d;
    r.hit = 1'b0;
    r.idx = '0;
    if (b >= ASCII_LC_A && b <= ASCII_LC_Z) begin
      d     = b - ASCII_LC_A;
      r.hit = 1'b1;
      r.idx = d[ALPHA_AW-1:0];
    end else if (b >= ASCII_UC_A && b <= ASCII_UC_Z) begin
      d     = b - ASCII_UC_A;
      r.hit = 1'b1;
      r.idx = d[ALPHA_AW-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/kwsc_ram.sv
// ----------------------------------------------------------------------------
// kwsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kwsc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 26
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/kwsc_regs.sv
// ----------------------------------------------------------------------------
// kwsc_regs
// APB register file: keyword, keyword length and direction.
// ----------------------------------------------------------------------------
module kwsc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kwsc_pkg::CFG_AW-1:0]  paddr,
  input  logic [kwsc_pkg::CFG_DW-1:0]  pwdata,
  output logic [kwsc_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output kwsc_pkg::cfg_t               cfg,
  output logic                         rebuild
);
  import kwsc_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:3]);
  assign wr     = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg     <= '0;
      rebuild <= 1'b0;
    end else begin
      rebuild <= 1'b0;
      if (wr) begin
        unique case (idx)
          REG_KEY_LETTERS: begin
            cfg.key_letters <= pwdata[63:0];
            rebuild         <= 1'b1;
          end
          REG_KEY_LENGTH: begin
            cfg.key_length <= pwdata[3:0];
            rebuild        <= 1'b1;
          end
          REG_DIRECTION: begin
            cfg.direction <= pwdata[0];
            rebuild       <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_KEY_LETTERS: prdata = cfg.key_letters;
      REG_KEY_LENGTH:  prdata = {60'd0, cfg.key_length};
      REG_DIRECTION:   prdata = {63'd0, cfg.direction};
      default:         prdata = '0;
    endcase
  end

endmodule

>>> design/kwsc_builder.sv
// ----------------------------------------------------------------------------
// kwsc_builder
// Sequencer that writes the active substitution table entry by entry.
// ----------------------------------------------------------------------------
module kwsc_builder #(
  parameter int MAX_KEY_LETTERS = kwsc_pkg::MAX_KEY_LETTERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  kwsc_pkg::cfg_t    cfg,
  input  logic              rebuild,
  output logic              busy,
  output kwsc_pkg::ram_wr_t wr
);
  import kwsc_pkg::*;

  localparam logic [ALPHA_AW-1:0] KEY_LAST   = ALPHA_AW'(MAX_KEY_LETTERS - 1);
  localparam logic [ALPHA_AW-1:0] ALPHA_LAST = ALPHA_AW'(ALPHA_SIZE - 1);
  localparam logic [3:0]          KEY_MAX    = 4'(MAX_KEY_LETTERS);

  bld_state_t          state, state_next;
  logic [ALPHA_AW-1:0] cnt, cnt_next;
  logic [ALPHA_AW-1:0] fill, fill_next;
  logic [ALPHA_SIZE-1:0] taken, taken_next;

  logic [3:0]          count;
  logic [7:0]          key_byte;
  letter_t             kl;
  logic                emit;
  logic [ALPHA_AW-1:0] emit_letter;

  // clamp the keyword length
  assign count    = (cfg.key_length > KEY_MAX) ? KEY_MAX : cfg.key_length;
  assign key_byte = cfg.key_letters[{cnt[2:0], 3'b000} +: 8];
  assign kl       = letter_index(key_byte);
  // a pending rebuild counts as busy so no word sees the old table
  assign busy     = (state != BLD_IDLE) || rebuild;

  // state and counters; reset starts a build of the identity table
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BLD_KEY;
      cnt   <= '0;
      fill  <= '0;
      taken <= '0;
    end else if (rebuild) begin
      state <= BLD_KEY;
      cnt   <= '0;
      fill  <= '0;
      taken <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      fill  <= fill_next;
      taken <= taken_next;
    end
  end

  // next state and table write
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    fill_next   = fill;
    taken_next  = taken;
    emit        = 1'b0;
    emit_letter = cnt;
    unique case (state)
      BLD_IDLE: ;
      BLD_KEY: begin
        // keyword letters in order, first occurrence only
        emit_letter = kl.idx;
        emit        = kl.hit && (cnt < {1'b0, count}) && !taken[kl.idx];
        if (cnt == KEY_LAST) begin
          state_next = BLD_FILL;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      BLD_FILL: begin
        // remaining letters a to z
        emit_letter = cnt;
        emit        = !taken[cnt];
        if (cnt == ALPHA_LAST) begin
          state_next = BLD_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      default: state_next = BLD_IDLE;
    endcase
    if (emit) begin
      taken_next[emit_letter] = 1'b1;
      fill_next               = fill + 1'b1;
    end
    // encrypt stores mixed[fill] = letter, decrypt stores inverse[letter] = fill
    wr.en   = emit;
    wr.addr = cfg.direction ? emit_letter : fill;
    wr.data = cfg.direction ? fill : emit_letter;
  end

endmodule

>>> design/keyword_substitution_cipher.sv
// An accepted word passes the lookup stage (registered table read) and then the
// output register. Throughput: one word per cycle while the output is not stalled
// and no table build runs, set by the single table read port. After reset, and
// after a register write, the table is rebuilt; s_tready stays low meanwhile.
// Reset is synchronous, active high, and loads the identity alphabet.
// ----------------------------------------------------------------------------
// keyword_substitution_cipher
// Keyword mixed-alphabet substitution over a byte stream, table in a RAM.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher #(
  parameter int MAX_KEY_LETTERS = kwsc_pkg::MAX_KEY_LETTERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] in_char
  input  logic                        s_tlast,   // in_last
  // output stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,   // [7:0] out_char
  output logic                        m_tlast,   // out_last
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kwsc_pkg::CFG_AW-1:0] paddr,
  input  logic [kwsc_pkg::CFG_DW-1:0] pwdata,
  output logic [kwsc_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import kwsc_pkg::*;

  cfg_t                cfg;
  logic                rebuild;
  logic                busy;
  ram_wr_t             wr;
  letter_t             lk;
  logic                s_accept;
  logic                advance;
  logic [ALPHA_AW-1:0] raddr;
  logic [ALPHA_AW-1:0] rdata;

  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;
  logic       s1_hit;

  kwsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .rebuild (rebuild)
  );

  kwsc_builder #(
    .MAX_KEY_LETTERS (MAX_KEY_LETTERS)
  ) u_builder (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .rebuild (rebuild),
    .busy    (busy),
    .wr      (wr)
  );

  kwsc_ram #(
    .WIDTH (ALPHA_AW),
    .DEPTH (ALPHA_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (s_accept),
    .raddr (raddr),
    .rdata (rdata)
  );

  // handshake: lookup stage moves on when the output register frees up
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !busy && (!s1_valid || advance);
  assign s_accept = s_tvalid && s_tready;
  assign lk       = letter_index(s_tdata);
  assign raddr    = lk.hit ? lk.idx : '0;

  // lookup stage: table read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_char <= s_tdata;
      s1_last <= s_tlast;
      s1_hit  <= lk.hit;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      m_tdata <= s1_hit ? (ASCII_LC_A + {3'b000, rdata}) : s1_char;
      m_tlast <= s1_last;
    end
  end

  // no word taken while the table is being rebuilt
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready) else $error("input accepted during table build");

  // table is written only by the builder sequence
  a_write_in_build: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> busy) else $error("table write outside build");

  // an accepted word occupies the lookup stage next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> s1_valid) else $error("accepted word lost");

  // output letters of a substituted word are lower case
  a_lower_case: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_valid && s1_hit) |=>
      (m_tdata >= ASCII_LC_A && m_tdata <= ASCII_LC_Z))
    else $error("substituted byte not a lower-case letter");

endmodule

>>> tb/sv/tb_keyword_substitution_cipher.sv
// ----------------------------------------------------------------------------
// tb_keyword_substitution_cipher
// Self-checking bench for the keyword substitution cipher. Each test phase
// after the first programs a keyword, its length and a direction over the
// register port, then streams bytes through. A scoreboard builds its own mixed
// alphabet from the register values and checks every output word in order.
// ----------------------------------------------------------------------------
module tb_keyword_substitution_cipher;
  import kwsc_pkg::*;

  // one word on either stream
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } cipher_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the registers and of both lookup tables
  // --------------------------------------------------------------------------
  class subst_scoreboard;
    logic [63:0]         key_letters;
    logic [3:0]          key_length;
    logic                direction;
    logic [ALPHA_AW-1:0] cipher_tab [ALPHA_SIZE];
    logic [ALPHA_AW-1:0] plain_tab  [ALPHA_SIZE];
    cipher_word_t        pending_words [$];
    int                  mismatches;

    function new();
      key_letters = '0;
      key_length  = '0;
      direction   = 1'b0;
      mismatches  = 0;
      rebuild();
    endfunction

    // case-folded letter position; returns 0 for anything but A-Z / a-z
    function bit is_letter(input logic [7:0] b, output logic [ALPHA_AW-1:0] pos);
      logic [7:0] d;
      d   = 8'h00;
      pos = '0;
      if (b >= ASCII_LC_A && b <= ASCII_LC_Z) d = b - ASCII_LC_A;
      else if (b >= ASCII_UC_A && b <= ASCII_UC_Z) d = b - ASCII_UC_A;
      else return 1'b0;
      pos = d[ALPHA_AW-1:0];
      return 1'b1;
    endfunction

    // keyword letters first (repeats dropped), then the unused letters
    function void rebuild();
      bit                  used [ALPHA_SIZE];
      int                  fill;
      int                  span;
      logic [ALPHA_AW-1:0] pos;
      fill = 0;
      span = (key_length > MAX_KEY_LETTERS_DEF) ? MAX_KEY_LETTERS_DEF : key_length;
      for (int i = 0; i < ALPHA_SIZE; i++) used[i] = 1'b0;
      for (int i = 0; i < span; i++) begin
        if (is_letter(key_letters[8*i +: 8], pos) && !used[pos]) begin
          used[pos]        = 1'b1;
          cipher_tab[fill] = pos;
          fill++;
        end
      end
      for (int i = 0; i < ALPHA_SIZE; i++) begin
        if (!used[i]) begin
          cipher_tab[fill] = i[ALPHA_AW-1:0];
          fill++;
        end
      end
      for (int i = 0; i < ALPHA_SIZE; i++) plain_tab[cipher_tab[i]] = i[ALPHA_AW-1:0];
    endfunction

    function void set_reg(input reg_idx_t idx, input logic [63:0] value);
      case (idx)
        REG_KEY_LETTERS: key_letters = value;
        REG_KEY_LENGTH:  key_length  = value[3:0];
        REG_DIRECTION:   direction   = value[0];
        default: return;
      endcase
      rebuild();
    endfunction

    function logic [7:0] substitute(input logic [7:0] b);
      logic [ALPHA_AW-1:0] pos;
      if (!is_letter(b, pos)) return b;
      return ASCII_LC_A + {3'b000, (direction ? plain_tab[pos] : cipher_tab[pos])};
    endfunction

    function void report_fault(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void note_in_word(input logic [7:0] ch, input logic last);
      cipher_word_t w;
      w.ch   = substitute(ch);
      w.last = last;
      pending_words.push_back(w);
    endfunction

    function void check_out_word(input logic [7:0] ch, input logic last);
      cipher_word_t w;
      if (pending_words.size() == 0) begin
        report_fault($sformatf("unexpected word char=%02h last=%0b", ch, last));
        return;
      end
      w = pending_words.pop_front();
      if (w.ch !== ch)
        report_fault($sformatf("out_char expected %02h got %02h", w.ch, ch));
      if (w.last !== last)
        report_fault($sformatf("out_last expected %0b got %0b (char %02h)", w.last, last, ch));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [7:0]        s_tdata;   // [7:0] in_char
  logic              s_tlast;   // in_last
  logic              m_tvalid;
  logic              m_tready;
  logic [7:0]        m_tdata;   // [7:0] out_char
  logic              m_tlast;   // out_last
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  subst_scoreboard sb = new;

  // idle rates in percent, and a request for one long receiver hold-off
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_off_req   = 1'b0;

  keyword_substitution_cipher dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    #200000;
    $display("end of test: mismatches");
    $finish;
  end

  // monitor: log accepted input words, then check accepted output words
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_in_word(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_out_word(m_tdata, m_tlast);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = 90;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic reg_write(input reg_idx_t idx, input logic [63:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic configure(input logic [63:0] key, input logic [3:0] len, input logic dir);
    reg_write(REG_KEY_LETTERS, key);
    reg_write(REG_KEY_LENGTH, {60'd0, len});
    reg_write(REG_DIRECTION, {63'd0, dir});
  endtask

  // one word on the input stream, with an optional random gap first
  task automatic send_byte(input logic [7:0] ch, input logic last);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    s_tvalid <= 1'b0;
  endtask

  // wait until every predicted word has come out, then let the pipe settle
  task automatic drain();
    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] pack_key(input string s);
    logic [63:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < 8; i++) k[8*i +: 8] = s[i];
    return k;
  endfunction

  // mostly letters of either case, the rest any byte
  function automatic logic [7:0] rand_char(input int any_pct);
    logic [7:0] base;
    if ($urandom_range(99) < any_pct) return 8'($urandom_range(255));
    base = $urandom_range(1) ? ASCII_UC_A : ASCII_LC_A;
    return base + 8'($urandom_range(25));
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [63:0] key;
    logic [3:0]  len;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct  = 26;
    recv_stall_pct = 49;

    // identity alphabet out of reset: byte extremes and letter boundaries
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(ASCII_LC_A, 1'b0);
    send_byte(ASCII_LC_Z, 1'b1);
    send_byte(ASCII_UC_A, 1'b0);
    send_byte(ASCII_UC_Z, 1'b0);
    send_byte(ASCII_UC_A - 8'd1, 1'b0);
    send_byte(ASCII_UC_Z + 8'd1, 1'b0);
    send_byte(ASCII_LC_A - 8'd1, 1'b0);
    send_byte(ASCII_LC_Z + 8'd1, 1'b1);
    s_tvalid <= 1'b0;
    drain();

    // mixed case keyword with repeats and a non-letter, both directions
    configure(pack_key("Zebra1zE"), 4'd8, 1'b0);
    send_text("abzY");
    drain();
    reg_write(REG_DIRECTION, 64'd1);
    send_text("zEy!");
    drain();

    // all non-letter keyword with an oversized length: identity
    configure('1, 4'd15, 1'b0);
    send_text("Mq");
    drain();

    // stray write to the unused index, then zero length: identity
    reg_write(REG_NONE, pack_key("junkjunk"));
    configure(pack_key("keyword"), 4'd0, 1'b1);
    send_text("gK");
    drain();

    // length above eight letters is capped
    configure(pack_key("qwertyui"), 4'd12, 1'b0);
    send_text("aZ");
    drain();

    // random phases: fresh keyword each time, idling pattern per stretch
    for (int ph = 0; ph < 13; ph++) begin
      if (ph == 4) begin
        send_idle_pct  = 49;
        recv_stall_pct = 26;
      end else if (ph == 9) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if ($urandom_range(3) == 0) reg_write(REG_NONE, {$urandom, $urandom});
      for (int i = 0; i < 8; i++) key[8*i +: 8] = rand_char(25);
      len = ($urandom_range(9) < 7) ? 4'($urandom_range(8, 1)) : 4'($urandom_range(15));
      configure(key, len, 1'($urandom_range(1)));
      for (int i = 0; i < 40; i++) begin
        if (ph == 1 && i == 5) hold_off_req = 1'b1;
        send_byte(rand_char(35), $urandom_range(5) == 0);
      end
      s_tvalid <= 1'b0;
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.pending_words.size() != 0)
      sb.report_fault($sformatf("%0d words never came out", sb.pending_words.size()));
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
